// File: rtl/bts_pkg.sv
package bts_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_U,
        S_SPLIT_U,
        S_MUL_V,
        S_SPLIT_V,
        S_MUL_YW,
        S_ADD_X,
        S_MUL_CC,
        S_LOAD,
        S_REDUCE,
        S_FETCH,
        S_PUSH,
        S_BM0,
        S_BT,
        S_BM1,
        S_BB,
        S_BD,
        S_BM2,
        S_BX,
        S_DONE
    } state_t;

    // Request kinds
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_TEX_WIDTH     = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] REG_WRAP_MODE     = 2'd3;

    // Channel layouts
    localparam logic [2:0] CH_GREY = 3'd1;
    localparam logic [2:0] CH_RGB  = 3'd3;
    localparam logic [2:0] CH_RGBA = 3'd4;

    localparam int         BYTE_ADDR_W = 18;
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0] WHITE_8_8  = 16'hFF00;
    localparam logic [7:0]  OPAQUE     = 8'hFF;

endpackage

// File: rtl/bts_ram.sv
module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bts_mul.sv
module bts_mul #(
    parameter int A_W = 26,
    parameter int B_W = 16,
    localparam int P_W = A_W + B_W + 1
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [A_W-1:0] a,
    input  logic        [B_W-1:0] b,
    output logic signed [P_W-1:0] prod
);

    // b is always a magnitude: widen it by a zero sign bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod <= a * $signed({1'b0, b});
        end
    end

endmodule

// File: rtl/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler over a byte-wide texture store. A write request
// stores one byte and holds busy while its address is folded into the store;
// a sample request raises done for one cycle once the blended pixel is ready.
// SH is the number of extra compare-and-subtract steps that fold a byte
// address into the store: 0 at the default sizes, more for a store under
// 2^17 bytes or a larger MAX_DIM. Sample timing is set by the single shared
// multiplier, which does every coordinate, address and blend product, and by
// the one read port of the store, one byte per cycle. With an unsupported
// channel count a sample returns white in the cycle after it is taken.
// The receiver cannot stall: red, green, blue and alpha are valid only in
// the cycle where done is high. The store is not cleared at reset; reading
// a texel that was never written returns arbitrary bytes.
module bilinear_texture_sampler_unit
    import bts_pkg::*;
#(
    parameter int MEM_BYTES = 262144,
    parameter int MAX_DIM   = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [BYTE_ADDR_W-1:0] byte_address,
    input  logic [7:0]             byte_value,
    input  logic signed [23:0]     coord_u,
    input  logic signed [23:0]     coord_v,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [8:0]             cfg_data,
    output logic                   done,
    output logic [15:0]            red,
    output logic [15:0]            green,
    output logic [15:0]            blue,
    output logic [15:0]            alpha
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int TIDX_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int MEMV_W = $clog2(MEM_BYTES + 1);
    localparam int RW     = (TIDX_W + 2 > BYTE_ADDR_W) ? TIDX_W + 2 : BYTE_ADDR_W;
    localparam int RED_W  = (RW > MEMV_W) ? RW : MEMV_W;
    localparam int SH_MAX = RED_W - MEMV_W;
    localparam int SH_W   = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;
    localparam int MA_W   = (TIDX_W + 1 > 26) ? TIDX_W + 1 : 26;
    localparam int MB_W   = (DIM_W > 16) ? DIM_W : 16;
    localparam int P_W    = MA_W + MB_W + 1;

    function automatic logic [16:0] fold_coord(input logic signed [23:0] c,
                                               input logic wrap);
        logic neg;
        logic over;
        neg  = c[23];
        over = !c[23] && (c[22:0] > 23'(ONE_Q16));
        if (wrap)
        begin
            return (neg || over) ? {1'b0, c[15:0]} : c[16:0];
        end
        if (neg)
        begin
            return '0;
        end
        if (over)
        begin
            return ONE_Q16;
        end
        return c[16:0];
    endfunction

    // Configuration
    logic [8:0] tex_width_reg;
    logic [8:0] tex_height_reg;
    logic [2:0] cc_reg;
    logic       wrap_reg;

    // Control
    state_t state_reg, state_next;
    logic [1:0]      k_reg, k_next;
    logic [2:0]      j_reg, j_next;
    logic [1:0]      c_reg, c_next;
    logic [SH_W-1:0] sh_reg, sh_next;

    // Payload
    logic              func_reg, func_next;
    logic [7:0]        byte_reg, byte_next;
    logic [16:0]       u_reg, u_next;
    logic [16:0]       v_reg, v_next;
    logic [DIM_W-1:0]  x0_reg, x0_next;
    logic [DIM_W-1:0]  x1_reg, x1_next;
    logic [DIM_W-1:0]  y0_reg, y0_next;
    logic [DIM_W-1:0]  y1_reg, y1_next;
    logic [15:0]       du_reg, du_next;
    logic [15:0]       dv_reg, dv_next;
    logic [TIDX_W-1:0] t_reg, t_next;
    logic [RED_W-1:0]  red_reg, red_next;
    logic [MEM_AW-1:0] addr_reg, addr_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       pix_reg [4];
    logic [31:0]       pix_next [4];
    logic [23:0]       top_reg, top_next;
    logic [23:0]       bot_reg, bot_next;
    logic signed [24:0] diff_reg, diff_next;
    logic [63:0]       res_reg, res_next;

    // Derived
    logic [DIM_W-1:0]  w_eff, h_eff, w_m1, h_m1;
    logic              bad_cc;
    logic [DIM_W-1:0]  x_split, y_split, x_sel, y_sel;
    logic [RED_W-1:0]  red_sub, red_step;
    logic [31:0]       unpacked;
    logic [7:0]        blend_base;
    logic [25:0]       blend_sum;
    logic [41:0]       mix_sum;
    logic signed [8:0] diff_a, diff_b;

    // Shared multiplier and store
    logic                   mul_en;
    logic signed [MA_W-1:0] mul_a;
    logic        [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;
    logic                   ram_we;
    logic [7:0]             ram_rdata;

    bts_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    bts_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (red_step[MEM_AW-1:0]),
        .wdata (byte_reg),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (tex_width_reg == 9'd0)
            w_eff = DIM_W'(1);
        else if (32'(tex_width_reg) > 32'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(tex_width_reg);
        if (tex_height_reg == 9'd0)
            h_eff = DIM_W'(1);
        else if (32'(tex_height_reg) > 32'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(tex_height_reg);
    end

    assign w_m1   = w_eff - DIM_W'(1);
    assign h_m1   = h_eff - DIM_W'(1);
    assign bad_cc = (cc_reg != CH_GREY) && (cc_reg != CH_RGB) && (cc_reg != CH_RGBA);

    assign x_split = prod[15+DIM_W:16];
    assign y_split = prod[15+DIM_W:16];
    assign x_sel   = k_reg[0] ? x1_reg : x0_reg;
    assign y_sel   = k_reg[1] ? y1_reg : y0_reg;

    // One restoring step of the address fold into the store
    assign red_sub  = RED_W'(MEM_BYTES) << sh_reg;
    assign red_step = (red_reg >= red_sub) ? red_reg - red_sub : red_reg;

    always_comb
    begin
        case (cc_reg)
            CH_GREY: unpacked = {cur_reg[7:0], cur_reg[7:0], cur_reg[7:0], OPAQUE};
            CH_RGB:  unpacked = {cur_reg[23:0], OPAQUE};
            default: unpacked = cur_reg;
        endcase
    end

    assign diff_a     = $signed({1'b0, pix_reg[1][31:24]}) - $signed({1'b0, pix_reg[0][31:24]});
    assign diff_b     = $signed({1'b0, pix_reg[3][31:24]}) - $signed({1'b0, pix_reg[2][31:24]});
    assign blend_base = (state_reg == S_BB) ? pix_reg[2][31:24] : pix_reg[0][31:24];
    assign blend_sum  = {2'b00, blend_base, 16'h0000} + prod[25:0];
    assign mix_sum    = {2'b00, top_reg, 16'h0000} + prod[41:0];

    // Multiplier operands
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_MUL_U:
            begin
                mul_a = MA_W'(u_reg);
                mul_b = MB_W'(w_m1);
            end
            S_MUL_V:
            begin
                mul_a = MA_W'(v_reg);
                mul_b = MB_W'(h_m1);
            end
            S_MUL_YW:
            begin
                mul_a = MA_W'(y_sel);
                mul_b = MB_W'(w_eff);
            end
            S_MUL_CC:
            begin
                mul_a = MA_W'(t_reg);
                mul_b = MB_W'(cc_reg);
            end
            S_BM0:
            begin
                mul_a = MA_W'(diff_a);
                mul_b = MB_W'(du_reg);
            end
            S_BM1:
            begin
                mul_a = MA_W'(diff_b);
                mul_b = MB_W'(du_reg);
            end
            S_BM2:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'(dv_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_WRITE)
                        state_next = S_REDUCE;
                    else if (bad_cc)
                        state_next = S_DONE;
                    else
                        state_next = S_MUL_U;
                end
            end
            S_MUL_U:   state_next = S_SPLIT_U;
            S_SPLIT_U: state_next = S_MUL_V;
            S_MUL_V:   state_next = S_SPLIT_V;
            S_SPLIT_V: state_next = S_MUL_YW;
            S_MUL_YW:  state_next = S_ADD_X;
            S_ADD_X:   state_next = S_MUL_CC;
            S_MUL_CC:  state_next = S_LOAD;
            S_LOAD:    state_next = S_REDUCE;
            S_REDUCE:
            begin
                if (sh_reg == '0)
                    state_next = (func_reg == FUNC_WRITE) ? S_IDLE : S_FETCH;
            end
            S_FETCH:
            begin
                if (j_reg == cc_reg)
                    state_next = S_PUSH;
            end
            S_PUSH:    state_next = (k_reg == 2'd3) ? S_BM0 : S_MUL_YW;
            S_BM0:     state_next = S_BT;
            S_BT:      state_next = S_BM1;
            S_BM1:     state_next = S_BB;
            S_BB:      state_next = S_BD;
            S_BD:      state_next = S_BM2;
            S_BM2:     state_next = S_BX;
            S_BX:      state_next = (c_reg == 2'd3) ? S_DONE : S_BM0;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        k_next    = k_reg;
        j_next    = j_reg;
        c_next    = c_reg;
        sh_next   = sh_reg;
        func_next = func_reg;
        byte_next = byte_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        x0_next   = x0_reg;
        x1_next   = x1_reg;
        y0_next   = y0_reg;
        y1_next   = y1_reg;
        du_next   = du_reg;
        dv_next   = dv_reg;
        t_next    = t_reg;
        red_next  = red_reg;
        addr_next = addr_reg;
        cur_next  = cur_reg;
        pix_next  = pix_reg;
        top_next  = top_reg;
        bot_next  = bot_reg;
        diff_next = diff_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    byte_next = byte_value;
                    u_next    = fold_coord(coord_u, wrap_reg);
                    v_next    = fold_coord(coord_v, wrap_reg);
                    red_next  = RED_W'(byte_address);
                    sh_next   = SH_W'(SH_MAX);
                    k_next    = '0;
                    c_next    = '0;
                    res_next  = {WHITE_8_8, WHITE_8_8, WHITE_8_8, WHITE_8_8};
                end
            end
            S_SPLIT_U:
            begin
                x0_next = x_split;
                x1_next = (x_split == w_m1) ? x_split : x_split + DIM_W'(1);
                du_next = prod[15:0];
            end
            S_SPLIT_V:
            begin
                y0_next = y_split;
                y1_next = (y_split == h_m1) ? y_split : y_split + DIM_W'(1);
                dv_next = prod[15:0];
            end
            S_ADD_X:
            begin
                t_next = prod[TIDX_W-1:0] + TIDX_W'(x_sel);
            end
            S_LOAD:
            begin
                red_next = RED_W'(prod[TIDX_W+1:0]);
                sh_next  = SH_W'(SH_MAX);
            end
            S_REDUCE:
            begin
                red_next = red_step;
                if (sh_reg != '0)
                begin
                    sh_next = sh_reg - SH_W'(1);
                end
                else
                begin
                    addr_next = red_step[MEM_AW-1:0];
                    j_next    = '0;
                    ram_we    = (func_reg == FUNC_WRITE);
                end
            end
            S_FETCH:
            begin
                // Issue one byte read a cycle; the data lands in the next cycle
                if (j_reg != cc_reg)
                begin
                    j_next    = j_reg + 3'd1;
                    addr_next = (addr_reg == MEM_AW'(MEM_BYTES - 1)) ? '0
                                                                    : addr_reg + MEM_AW'(1);
                end
                if (j_reg != 3'd0)
                begin
                    cur_next = {cur_reg[23:0], ram_rdata};
                end
            end
            S_PUSH:
            begin
                pix_next[0] = pix_reg[1];
                pix_next[1] = pix_reg[2];
                pix_next[2] = pix_reg[3];
                pix_next[3] = unpacked;
                k_next      = k_reg + 2'd1;
            end
            S_BT:
            begin
                top_next = blend_sum[23:0];
            end
            S_BB:
            begin
                bot_next = blend_sum[23:0];
            end
            S_BD:
            begin
                diff_next = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
            end
            S_BX:
            begin
                res_next = {res_reg[47:0], mix_sum[39:24]};
                // Bring the next channel to the top byte of every texel
                for (int i = 0; i < 4; i++)
                begin
                    pix_next[i] = {pix_reg[i][23:0], pix_reg[i][31:24]};
                end
                c_next = c_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 9'd1;
            tex_height_reg <= 9'd1;
            cc_reg         <= CH_RGBA;
            wrap_reg       <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:     tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT:    tex_height_reg <= cfg_data;
                REG_CHANNEL_COUNT: cc_reg         <= cfg_data[2:0];
                REG_WRAP_MODE:     wrap_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            c_reg     <= '0;
            sh_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            c_reg     <= c_next;
            sh_reg    <= sh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        byte_reg <= byte_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        du_reg   <= du_next;
        dv_reg   <= dv_next;
        t_reg    <= t_next;
        red_reg  <= red_next;
        addr_reg <= addr_next;
        cur_reg  <= cur_next;
        pix_reg  <= pix_next;
        top_reg  <= top_next;
        bot_reg  <= bot_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = (state_reg == S_DONE);
    assign red   = res_reg[63:48];
    assign green = res_reg[47:32];
    assign blue  = res_reg[31:16];
    assign alpha = res_reg[15:0];

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_busy_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_white_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_SAMPLE && bad_cc) |=> done)
        else $error("unsupported channel count did not return at once");

    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (j_reg <= cc_reg))
        else $error("byte fetch ran past the texel");

endmodule

// File: tb/sv/bilinear_texture_sampler_unit_tb.sv
module bilinear_texture_sampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    localparam int TEX_BYTES     = 262144;
    localparam int DIM_MAX       = 256;
    localparam int Q16_ONE       = 32'h10000;
    localparam int ITEM_TARGET   = 1050;
    localparam int QUIET_FROM    = ITEM_TARGET - 150;
    localparam int SETTLE_CYCLES = 80;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } pixel_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_WR, ROW_SMP} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [1:0]         idx;
        logic [8:0]         data;
        logic [17:0]        addr;
        logic [7:0]         value;
        logic signed [23:0] u;
        logic signed [23:0] v;
        logic               typed;
        pixel_t             pix;
    } step_t;

    localparam pixel_t NO_PIX    = '0;
    localparam pixel_t PIX_WHITE = '{WHITE_8_8, WHITE_8_8, WHITE_8_8, WHITE_8_8};
    localparam pixel_t PIX_RAMP  = '{16'h0A00, 16'h1400, 16'h1E00, 16'h2800};
    localparam pixel_t PIX_MID   = '{16'h8000, 16'h8000, 16'h8000, WHITE_8_8};
    localparam pixel_t PIX_DARK  = '{16'h4000, 16'h4000, 16'h4000, WHITE_8_8};

    localparam step_t DIRECTED_STEPS [29] = '{
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h0A, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00001, 8'h14, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00002, 8'h1E, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00003, 8'h28, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        // one-texel texture after reset: any coordinate lands on texel zero
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h000000, 24'h000000, 1'b1, PIX_RAMP},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h3FFFF, 8'hFF, 24'h800000, 24'h7FFFFF, 1'b1, PIX_RAMP},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h3FFFF, 8'hFF, 24'h7FFFFF, 24'h800000, 1'b0, NO_PIX},
        '{ROW_CFG, REG_CHANNEL_COUNT, 9'd0, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h010000, 24'h010000, 1'b1, PIX_WHITE},
        '{ROW_CFG, REG_CHANNEL_COUNT, 9'd7, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'hFFFFFF, 24'h000000, 1'b1, PIX_WHITE},
        '{ROW_CFG, REG_TEX_WIDTH, 9'd2, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_CFG, REG_TEX_HEIGHT, 9'd2, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_CFG, REG_CHANNEL_COUNT, 9'(CH_GREY), 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_CFG, REG_WRAP_MODE, 9'd0, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00001, 8'hFF, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00002, 8'h80, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_WR,  REG_TEX_WIDTH, 9'd0, 18'h00003, 8'h40, 24'h000000, 24'h000000, 1'b0, NO_PIX},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h008000, 24'h008000, 1'b0, NO_PIX},
        // clamp pins u to 0 and v to 1.0: bottom-left texel alone
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h800000, 24'h7FFFFF, 1'b1, PIX_MID},
        '{ROW_CFG, REG_WRAP_MODE, 9'd1, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        // exactly 1.0 survives repeat mode
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h010000, 24'h010000, 1'b1, PIX_DARK},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h018000, 24'hFF8000, 1'b0, NO_PIX},
        '{ROW_CFG, REG_TEX_WIDTH, 9'd0, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_CFG, REG_TEX_HEIGHT, 9'h1FF, 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h7FFFFF, 24'h7FFFFF, 1'b0, NO_PIX},
        '{ROW_CFG, REG_CHANNEL_COUNT, 9'(CH_RGB), 18'h0, 8'h00, 24'h0, 24'h0, 1'b0, NO_PIX},
        '{ROW_SMP, REG_TEX_WIDTH, 9'd0, 18'h00000, 8'h00, 24'h800000, 24'h000000, 1'b0, NO_PIX}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               func = FUNC_WRITE;
    logic [17:0]        byte_address = '0;
    logic [7:0]         byte_value = '0;
    logic signed [23:0] coord_u = '0;
    logic signed [23:0] coord_v = '0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = REG_TEX_WIDTH;
    logic [8:0]         cfg_data = '0;
    logic               done;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;

    // Mirror of the block: registers, texture store and which bytes hold data
    logic [8:0]  cfg_width = 9'd1;
    logic [8:0]  cfg_height = 9'd1;
    logic [2:0]  cfg_chan = CH_RGBA;
    logic        cfg_wrap = 1'b1;
    logic [7:0]  texels [0:TEX_BYTES-1];
    bit          written [0:TEX_BYTES-1];

    int unsigned tap_addr [4];
    int unsigned tap_du;
    int unsigned tap_dv;

    pixel_t expected_pixels [$];
    int     requests_taken = 0;
    int     mismatch_count = 0;
    int     idle_pct = 25;

    bilinear_texture_sampler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit layout_ok();
        return cfg_chan == CH_GREY || cfg_chan == CH_RGB || cfg_chan == CH_RGBA;
    endfunction

    function automatic int unsigned eff_dim(logic [8:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_MAX)
            return DIM_MAX;
        return d;
    endfunction

    function automatic int unsigned fold_q16(logic signed [23:0] c);
        int cs;
        cs = c;
        if (cfg_wrap)
            return (cs < 0 || cs > Q16_ONE) ? (cs & 32'hFFFF) : cs;
        if (cs < 0)
            return 0;
        if (cs > Q16_ONE)
            return Q16_ONE;
        return cs;
    endfunction

    // Work out the four texel base addresses and the blend weights
    function automatic void locate(logic signed [23:0] cu, logic signed [23:0] cv);
        int unsigned w, h, fu, fv, x0, y0, x1, y1;
        w = eff_dim(cfg_width);
        h = eff_dim(cfg_height);
        fu = fold_q16(cu) * (w - 1);
        fv = fold_q16(cv) * (h - 1);
        x0 = fu >> 16;
        y0 = fv >> 16;
        tap_du = fu & 32'hFFFF;
        tap_dv = fv & 32'hFFFF;
        x1 = (x0 + 1 > w - 1) ? x0 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? y0 : y0 + 1;
        tap_addr[0] = (y0 * w + x0) * cfg_chan;
        tap_addr[1] = (y0 * w + x1) * cfg_chan;
        tap_addr[2] = (y1 * w + x0) * cfg_chan;
        tap_addr[3] = (y1 * w + x1) * cfg_chan;
    endfunction

    function automatic logic [7:0] texel_channel(int unsigned base, int k);
        if (k == 3 && cfg_chan != CH_RGBA)
            return OPAQUE;
        if (cfg_chan == CH_GREY)
            return texels[base % TEX_BYTES];
        return texels[(base + k) % TEX_BYTES];
    endfunction

    function automatic pixel_t bilinear_pixel(logic signed [23:0] cu, logic signed [23:0] cv);
        logic [15:0]     ch [4];
        longint unsigned p [4];
        longint unsigned top, bot, mix;
        if (!layout_ok())
            return PIX_WHITE;
        locate(cu, cv);
        for (int k = 0; k < 4; k++)
        begin
            for (int t = 0; t < 4; t++)
                p[t] = texel_channel(tap_addr[t], k);
            top = p[0] * (Q16_ONE - tap_du) + p[1] * tap_du;
            bot = p[2] * (Q16_ONE - tap_du) + p[3] * tap_du;
            mix = top * (Q16_ONE - tap_dv) + bot * tap_dv;
            ch[k] = mix[39:24];
        end
        return '{ch[0], ch[1], ch[2], ch[3]};
    endfunction

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'($urandom_range(0, Q16_ONE));
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 24'h000000;
                    1: return 24'h010000;
                    2: return 24'h00FFFF;
                    default: return 24'h000001;
                endcase
            end
            5: return 24'(-$urandom_range(1, 3 * Q16_ONE));
            6: return 24'($urandom_range(Q16_ONE + 1, 4 * Q16_ONE));
            9: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 9'($urandom_range(1, 8));
        if (r == 7)
            return 9'($urandom_range(9, 64));
        case ($urandom_range(0, 6))
            0: return 9'd0;
            1: return 9'd2;
            2: return 9'd255;
            3: return 9'd256;
            4: return 9'd257;
            5: return 9'h1FF;
            default: return 9'($urandom_range(258, 511));
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Hold the request until taken, then update the mirror or queue the pixel
    task automatic issue(logic op, logic [17:0] addr, logic [7:0] value,
                         logic signed [23:0] cu, logic signed [23:0] cv,
                         logic typed, pixel_t typed_pix);
        start        <= 1'b1;
        func         <= op;
        byte_address <= addr;
        byte_value   <= value;
        coord_u      <= cu;
        coord_v      <= cv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == FUNC_WRITE)
        begin
            texels[addr]  = value;
            written[addr] = 1'b1;
        end
        else
        begin
            expected_pixels.push_back(typed ? typed_pix : bilinear_pixel(cu, cv));
        end
        requests_taken++;
        if (requests_taken < QUIET_FROM && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic write_byte(logic [17:0] addr, logic [7:0] value);
        issue(FUNC_WRITE, addr, value, 24'($urandom), 24'($urandom), 1'b0, NO_PIX);
    endtask

    // Fill any texel byte the sample will read that holds no data yet
    task automatic prime_taps(logic signed [23:0] cu, logic signed [23:0] cv);
        int unsigned a;
        if (!layout_ok())
            return;
        locate(cu, cv);
        for (int t = 0; t < 4; t++)
        begin
            for (int b = 0; b < cfg_chan; b++)
            begin
                a = (tap_addr[t] + b) % TEX_BYTES;
                if (!written[a])
                    write_byte(18'(a), 8'($urandom));
            end
        end
    endtask

    task automatic sample_at(logic signed [23:0] cu, logic signed [23:0] cv,
                             logic typed, pixel_t typed_pix);
        prime_taps(cu, cv);
        issue(FUNC_SAMPLE, 18'($urandom), 8'($urandom), cu, cv, typed, typed_pix);
    endtask

    // Drop start, wait for every pixel, then let a write in flight finish
    task automatic settle();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_TEX_WIDTH:     cfg_width = data;
            REG_TEX_HEIGHT:    cfg_height = data;
            REG_CHANNEL_COUNT: cfg_chan = data[2:0];
            REG_WRAP_MODE:     cfg_wrap = data[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [8:0] w, logic [8:0] h, logic [2:0] cc, logic wrap);
        settle();
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, 9'(cc));
        write_reg(REG_WRAP_MODE, 9'(wrap));
        cfg_write <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_result
        pixel_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("red of a result with no request waiting", red, 16'h0000);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red !== want.red)
                    report_mismatch("red", red, want.red);
                if (green !== want.green)
                    report_mismatch("green", green, want.green);
                if (blue !== want.blue)
                    report_mismatch("blue", blue, want.blue);
                if (alpha !== want.alpha)
                    report_mismatch("alpha", alpha, want.alpha);
            end
        end
    end

    initial
    begin
        step_t       s;
        int          phase;
        int          burst;
        int          sel;
        int unsigned region;
        logic [2:0]  cc;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_STEPS); i++)
        begin
            s = DIRECTED_STEPS[i];
            case (s.kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(s.idx, s.data);
                    cfg_write <= 1'b0;
                end
                ROW_WR:  write_byte(s.addr, s.value);
                default: sample_at(s.u, s.v, s.typed, s.pix);
            endcase
        end

        phase = 0;
        while (requests_taken < ITEM_TARGET)
        begin
            // open with the extreme shapes, then wander
            case (phase)
                0: program_regs(9'd256, 9'd256, CH_RGBA, 1'b1);
                1: program_regs(9'd0, 9'h1FF, CH_RGB, 1'b0);
                2: program_regs(9'd257, 9'd3, CH_GREY, 1'b1);
                3: program_regs(9'd3, 9'd4, 3'd2, 1'b0);
                default:
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        case ($urandom_range(0, 2))
                            0: cc = CH_GREY;
                            1: cc = CH_RGB;
                            default: cc = CH_RGBA;
                        endcase
                    end
                    else
                    begin
                        cc = 3'($urandom_range(0, 7));
                    end
                    program_regs(pick_dim(), pick_dim(), cc, 1'($urandom_range(0, 1)));
                end
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 50;
            endcase
            burst = $urandom_range(25, 60);
            for (int n = 0; n < burst && requests_taken < ITEM_TARGET; n++)
            begin
                sel = $urandom_range(0, 99);
                region = eff_dim(cfg_width) * eff_dim(cfg_height) * cfg_chan;
                if (sel < 60)
                    sample_at(rand_coord(), rand_coord(), 1'b0, NO_PIX);
                else if (sel < 85 && layout_ok())
                    write_byte(18'($urandom_range(0, region - 1)), 8'($urandom));
                else
                    write_byte(18'($urandom), 8'($urandom));
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
